[rtl/crs_pkg.sv]
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the Catmull-Rom spline evaluator
// Stream layouts, command and register codes, and the lane select bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crs_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = 7;
  localparam int CoordW    = 32;
  localparam int FracW     = 16;
  localparam int LW        = FracW + 1;   // local t, 0..65536
  localparam int SumW      = 56;          // blend sum at 2^-16 scale
  localparam int FifoDepth = 8;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int InDataW   = 136;
  localparam int OutDataW  = 3 * CoordW;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_LOOP_MODE   = 1'b0,
    CFG_POINT_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               pad;
    logic signed [CoordW-1:0] curve_param;
    logic signed [CoordW-1:0] coord_z;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_x;
    logic [IdxW-1:0]          point_index;
  } in_tdata_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_z;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_x;
  } out_tdata_t;

  // store addresses of the four control points and local t of one request
  typedef struct packed {
    logic [3:0][IdxW-1:0] idx;
    logic [LW-1:0]        l;
  } sel_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

[rtl/crs_front.sv]
// ----------------------------------------------------------------------------
// crs_front: segment and neighbor selection, shared powers of local t
// Splits t into segment and local t, picks four store addresses, and
// computes u^2 and u^3 once for all lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              eval_i,
  input  logic                              loop_mode_i,
  input  logic [crs_pkg::CntW-1:0]          point_count_i,
  input  logic signed [crs_pkg::CoordW-1:0] curve_param_i,
  output crs_pkg::sel_t                     sel_o,
  output logic [crs_pkg::LW-1:0]            l_o,
  output logic [crs_pkg::LW-1:0]            u2_o,
  output logic [crs_pkg::LW-1:0]            u3_o,
  output crs_pkg::ctl_t                     ctl_o
);

  localparam int PW    = crs_pkg::IdxW + 2;
  localparam int ProdW = crs_pkg::FracW + crs_pkg::CntW;
  localparam int SqW   = 2 * crs_pkg::LW;
  localparam int Stages = 5;

  function automatic logic [crs_pkg::IdxW-1:0] pick_idx(
    input logic signed [PW-1:0]     p,
    input logic [crs_pkg::CntW-1:0] n,
    input logic                     loop_m
  );
    logic signed [PW-1:0] sn;
    logic signed [PW-1:0] w;
    sn = $signed({1'b0, n});
    w  = p;
    if (loop_m) begin
      if (w < 0) w = w + sn;
      if (w >= sn) w = w - sn;
      if (w >= sn) w = w - sn;   // one point: up to two wraps
    end else begin
      if (p < 0) w = '0;
      else if (p >= sn) w = sn - PW'(1);
    end
    return w[crs_pkg::IdxW-1:0];
  endfunction

  logic [crs_pkg::CntW-1:0]   n;
  logic                       t_neg;
  logic                       t_end;
  logic                       direct;
  logic [ProdW-1:0]           prod;
  logic [crs_pkg::IdxW-1:0]   seg;
  logic [crs_pkg::IdxW-1:0]   seg_raw;
  logic [crs_pkg::FracW-1:0]  l_raw;
  logic [crs_pkg::IdxW-1:0]   k_end;
  logic signed [PW-1:0]       base;
  crs_pkg::sel_t              sel_d;
  crs_pkg::sel_t              sel_q;
  logic [SqW-1:0]             sq;
  logic [SqW-1:0]             cu;
  logic [crs_pkg::LW-1:0]     l2_q, u2_q;
  logic [crs_pkg::LW-1:0]     l3_q, u2b_q, u3_q;
  crs_pkg::ctl_t              ctl_d;
  crs_pkg::ctl_t              ctl_q [Stages];

  always_comb begin
    n = (point_count_i > crs_pkg::CntW'(crs_pkg::MaxPoints))
        ? crs_pkg::CntW'(crs_pkg::MaxPoints) : point_count_i;
    t_neg   = curve_param_i[crs_pkg::CoordW-1];
    t_end   = !t_neg && (|curve_param_i[crs_pkg::CoordW-2:crs_pkg::FracW]);
    direct  = !loop_mode_i && (t_neg || t_end);
    prod    = ProdW'(curve_param_i[crs_pkg::FracW-1:0]) * ProdW'(n);
    seg_raw = prod[crs_pkg::FracW+crs_pkg::IdxW-1:crs_pkg::FracW];
    l_raw   = prod[crs_pkg::FracW-1:0];
    k_end   = t_neg ? '0 : crs_pkg::IdxW'(n - crs_pkg::CntW'(1));

    // exact boundary: previous segment with local t of one
    if (l_raw == '0 && seg_raw != '0) begin
      seg     = seg_raw - crs_pkg::IdxW'(1);
      sel_d.l = crs_pkg::LW'(1) << crs_pkg::FracW;
    end else begin
      seg     = seg_raw;
      sel_d.l = {1'b0, l_raw};
    end

    base = $signed({2'b00, seg}) - PW'(1);
    for (int k = 0; k < 4; k++) begin
      sel_d.idx[k] = pick_idx(base + PW'(k), n, loop_mode_i);
    end

    // open ends: all taps on one point with l = 0 reproduce it exactly
    if (direct) begin
      sel_d.l = '0;
      for (int k = 0; k < 4; k++) begin
        sel_d.idx[k] = k_end;
      end
    end

    ctl_d.valid = eval_i;
    ctl_d.zero  = (n == '0);
  end

  assign sq = SqW'(sel_q.l) * SqW'(sel_q.l);
  assign cu = SqW'(u2_q) * SqW'(l2_q);

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    l2_q  <= sel_q.l;
    u2_q  <= sq[crs_pkg::LW+crs_pkg::FracW-1:crs_pkg::FracW];
    l3_q  <= l2_q;
    u2b_q <= u2_q;
    u3_q  <= cu[crs_pkg::LW+crs_pkg::FracW-1:crs_pkg::FracW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        ctl_q[s] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_d;
      for (int s = 1; s < Stages; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  assign sel_o = sel_q;
  assign l_o   = l3_q;
  assign u2_o  = u2b_q;
  assign u3_o  = u3_q;
  assign ctl_o = ctl_q[Stages-1];

endmodule

[rtl/crs_lane.sv]
// ----------------------------------------------------------------------------
// crs_lane: one coordinate lane of the spline evaluator
// Holds the coordinate store (one copy per tap) and the blend pipeline:
// read, coefficient, multiply, sum, then rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_lane (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [crs_pkg::IdxW-1:0]          wr_addr_i,
  input  logic signed [crs_pkg::CoordW-1:0] wr_data_i,
  input  crs_pkg::sel_t                     sel_i,
  input  logic [crs_pkg::LW-1:0]            l_i,
  input  logic [crs_pkg::LW-1:0]            u2_i,
  input  logic [crs_pkg::LW-1:0]            u3_i,
  output logic signed [crs_pkg::CoordW-1:0] res_o
);

  localparam int AbW  = crs_pkg::CoordW + 4;
  localparam int CW   = crs_pkg::CoordW + 1;
  localparam int ClW  = CW + crs_pkg::LW + 1;
  localparam int AuW  = AbW + crs_pkg::LW + 1;
  localparam int SumW = crs_pkg::SumW;
  localparam int QW   = SumW - crs_pkg::FracW - 1;
  localparam int HiW  = QW - crs_pkg::CoordW + 1;

  logic signed [crs_pkg::CoordW-1:0] mem_q [4][crs_pkg::MaxPoints];
  logic signed [crs_pkg::CoordW-1:0] p_q [4];
  logic signed [AbW-1:0]             e0, e1, e2, e3;
  logic signed [AbW-1:0]             a_d, b_d;
  logic signed [CW-1:0]              c_d;
  logic signed [AbW-1:0]             a_q, b_q;
  logic signed [CW-1:0]              c_q;
  logic signed [crs_pkg::CoordW-1:0] p1_q, p1b_q;
  logic signed [ClW-1:0]             cl_q;
  logic signed [AuW-1:0]             au_q, bu_q;
  logic signed [SumW-1:0]            sum_d, sum_q;
  logic signed [SumW-1:0]            rnd;
  logic [QW-1:0]                     q;
  logic [HiW-1:0]                    hi;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int k = 0; k < 4; k++) begin
        mem_q[k][wr_addr_i] <= wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      p_q[k] <= mem_q[k][sel_i.idx[k]];
    end
  end

  always_comb begin
    e0  = {{(AbW-crs_pkg::CoordW){p_q[0][crs_pkg::CoordW-1]}}, p_q[0]};
    e1  = {{(AbW-crs_pkg::CoordW){p_q[1][crs_pkg::CoordW-1]}}, p_q[1]};
    e2  = {{(AbW-crs_pkg::CoordW){p_q[2][crs_pkg::CoordW-1]}}, p_q[2]};
    e3  = {{(AbW-crs_pkg::CoordW){p_q[3][crs_pkg::CoordW-1]}}, p_q[3]};
    // a = 2p0 - 5p1 + 4p2 - p3, b = 3p1 - p0 - 3p2 + p3
    a_d = (e0 <<< 1) + (e2 <<< 2) - (e1 + (e1 <<< 2)) - e3;
    b_d = (e1 + (e1 <<< 1)) + e3 - (e2 + (e2 <<< 1)) - e0;
    c_d = e2[CW-1:0] - e0[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    p1_q  <= p_q[1];
    cl_q  <= c_q * $signed({1'b0, l_i});
    au_q  <= a_q * $signed({1'b0, u2_i});
    bu_q  <= b_q * $signed({1'b0, u3_i});
    p1b_q <= p1_q;
    sum_q <= sum_d;
  end

  always_comb begin
    sum_d = {{(SumW-crs_pkg::CoordW-crs_pkg::FracW-1){p1b_q[crs_pkg::CoordW-1]}},
             p1b_q, {(crs_pkg::FracW+1){1'b0}}}
          + {{(SumW-ClW){cl_q[ClW-1]}}, cl_q}
          + {{(SumW-AuW){au_q[AuW-1]}}, au_q}
          + {{(SumW-AuW){bu_q[AuW-1]}}, bu_q};
  end

  // divide by 2^17, ties toward plus infinity, then saturate
  always_comb begin
    rnd = sum_q + (SumW'(1) <<< crs_pkg::FracW);
    q   = rnd[SumW-1:crs_pkg::FracW+1];
    hi  = q[QW-1:crs_pkg::CoordW-1];
    if ((&hi) || !(|hi)) begin
      res_o = q[crs_pkg::CoordW-1:0];
    end else if (hi[HiW-1]) begin
      res_o = {1'b1, {(crs_pkg::CoordW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(crs_pkg::CoordW-1){1'b1}}};
    end
  end

endmodule

[rtl/crs_merge.sv]
// ----------------------------------------------------------------------------
// crs_merge: lane merge and output queue
// Joins the three lane results into one result, queues it, and grants
// input credit so the queue can never overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              eval_i,
  input  crs_pkg::ctl_t                     ctl_i,
  input  logic signed [crs_pkg::CoordW-1:0] x_i,
  input  logic signed [crs_pkg::CoordW-1:0] y_i,
  input  logic signed [crs_pkg::CoordW-1:0] z_i,
  output logic                              credit_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output crs_pkg::out_tdata_t               m_tdata_o
);

  localparam int CntW = crs_pkg::FifoAw + 1;

  crs_pkg::out_tdata_t       fifo_q [crs_pkg::FifoDepth];
  crs_pkg::out_tdata_t       wr_data;
  logic [crs_pkg::FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]            count_q, pend_q;
  logic                       push, pop;

  assign push = ctl_i.valid;
  assign pop  = m_tvalid_o && m_tready_i;

  always_comb begin
    if (ctl_i.zero) begin
      wr_data = '0;
    end else begin
      wr_data.out_x = x_i;
      wr_data.out_y = y_i;
      wr_data.out_z = z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      pend_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + crs_pkg::FifoAw'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + crs_pkg::FifoAw'(1);
      count_q <= count_q + CntW'(push) - CntW'(pop);
      // requests in flight or queued
      pend_q  <= pend_q + CntW'(eval_i) - CntW'(pop);
    end
  end

  assign credit_o   = pend_q < CntW'(crs_pkg::FifoDepth);
  assign m_tvalid_o = count_q != '0;
  assign m_tdata_o  = fifo_q[rd_ptr_q];

endmodule

[rtl/catmull_rom_spline_eval.sv]
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval: uniform Catmull-Rom curve evaluator, 3 lanes
// Requests pass the front, the lanes and the output queue, in order.
// Throughput: one request per cycle; the 8-entry output queue sets how many
// results may be pending before the input stalls.
// Reset: loop mode and point count clear, pipeline and queue empty; the point
// store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module catmull_rom_spline_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_index, coord_x, coord_y, coord_z, curve_param, zero pad
  input  logic [crs_pkg::InDataW-1:0]   s_axis_tdata,
  // cmd
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_x, out_y, out_z
  output logic [crs_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [crs_pkg::CntW-1:0]      cfg_data_i
);

  crs_pkg::in_tdata_t              din;
  crs_pkg::out_tdata_t             dout;
  crs_pkg::cmd_e                   cmd;
  logic                            accept, load_en, eval_en;
  logic                            loop_mode_q;
  logic [crs_pkg::CntW-1:0]        point_count_q;
  crs_pkg::sel_t                   sel;
  crs_pkg::ctl_t                   ctl;
  logic [crs_pkg::LW-1:0]          l, u2, u3;
  logic signed [crs_pkg::CoordW-1:0] res_x, res_y, res_z;

  assign din     = s_axis_tdata;
  assign cmd     = crs_pkg::cmd_e'(s_axis_tuser[0]);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign load_en = accept && (cmd == crs_pkg::CMD_LOAD);
  assign eval_en = accept && (cmd == crs_pkg::CMD_EVAL);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q   <= 1'b0;
      point_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (crs_pkg::cfg_idx_e'(cfg_index_i))
        crs_pkg::CFG_LOOP_MODE:   loop_mode_q   <= cfg_data_i[0];
        crs_pkg::CFG_POINT_COUNT: point_count_q <= cfg_data_i;
        default:                  loop_mode_q   <= loop_mode_q;
      endcase
    end
  end

  crs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eval_i        (eval_en),
    .loop_mode_i   (loop_mode_q),
    .point_count_i (point_count_q),
    .curve_param_i (din.curve_param),
    .sel_o         (sel),
    .l_o           (l),
    .u2_o          (u2),
    .u3_o          (u3),
    .ctl_o         (ctl)
  );

  crs_lane u_lane_x (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (din.point_index),
    .wr_data_i (din.coord_x),
    .sel_i     (sel),
    .l_i       (l),
    .u2_i      (u2),
    .u3_i      (u3),
    .res_o     (res_x)
  );

  crs_lane u_lane_y (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (din.point_index),
    .wr_data_i (din.coord_y),
    .sel_i     (sel),
    .l_i       (l),
    .u2_i      (u2),
    .u3_i      (u3),
    .res_o     (res_y)
  );

  crs_lane u_lane_z (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (din.point_index),
    .wr_data_i (din.coord_z),
    .sel_i     (sel),
    .l_i       (l),
    .u2_i      (u2),
    .u3_i      (u3),
    .res_o     (res_z)
  );

  crs_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .eval_i     (eval_en),
    .ctl_i      (ctl),
    .x_i        (res_x),
    .y_i        (res_y),
    .z_i        (res_z),
    .credit_o   (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (dout)
  );

  assign m_axis_tdata = dout;

endmodule
